@@ hw/rtl/tspg_pkg.sv @@
// ----------------------------------------------------------------------------
// tspg_pkg
// Types and constants shared by the trapezoidal step pulse generator.
// ----------------------------------------------------------------------------
package tspg_pkg;

    localparam logic [12:0] INTERVAL_CAP   = 13'd5000;
    localparam logic [12:0] START_INTERVAL = 13'd100;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_SET   = 2'd2,
        OP_LOAD  = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TICK,
        ST_PLAN_ABS,
        ST_PLAN_SPLIT,
        ST_PHASE,
        ST_MUL,
        ST_DIV,
        ST_RDREQ,
        ST_RDDATA,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] target_steps;
        logic [4:0]         table_index;
        logic [15:0]        table_value;
    } cmd_t;

    typedef struct packed {
        logic               step_pulse;
        logic               step_direction;
        logic signed [31:0] position_steps;
        logic               moving;
        logic               move_done;
        logic [12:0]        interval_us;
    } rsp_t;

endpackage

@@ hw/rtl/tspg_ram.sv @@
// ----------------------------------------------------------------------------
// tspg_ram
// Generic single write port RAM with registered read.
// ----------------------------------------------------------------------------
module tspg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/tspg_div.sv @@
// ----------------------------------------------------------------------------
// tspg_div
// Bit-serial restoring divider for the table phase index. The caller
// guarantees the quotient fits in QUOT_W bits; one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tspg_div #(
    parameter int QUOT_W = 6
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [32+QUOT_W-2:0]   numer,
    input  logic [31:0]            denom,
    output logic                   done,
    output logic [QUOT_W-1:0]      quot
);

    localparam int CNT_W = $clog2(QUOT_W + 1);

    logic              busy_reg,  busy_next;
    logic              done_reg,  done_next;
    logic [CNT_W-1:0]  cnt_reg,   cnt_next;
    logic [31:0]       rem_reg,   rem_next;
    logic [QUOT_W-1:0] low_reg,   low_next;
    logic [QUOT_W-1:0] quot_reg,  quot_next;
    logic [31:0]       den_reg,   den_next;

    logic [32:0] trial;
    logic [33:0] diff;

    assign trial = {rem_reg, low_reg[QUOT_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        low_next  = low_reg;
        quot_next = quot_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(QUOT_W);
            // upper bits are already below the divisor
            rem_next  = {1'b0, numer[32+QUOT_W-2:QUOT_W]};
            low_next  = numer[QUOT_W-1:0];
            den_next  = denom;
        end
        else if (busy_reg)
        begin
            low_next = {low_reg[QUOT_W-2:0], 1'b0};
            if (!diff[33])
            begin
                rem_next  = diff[31:0];
                quot_next = {quot_reg[QUOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial[31:0];
                quot_next = {quot_reg[QUOT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        low_reg  <= low_next;
        quot_reg <= quot_next;
        den_reg  <= den_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

@@ hw/rtl/trapezoidal_step_pulse_generator_core.sv @@
// ----------------------------------------------------------------------------
// trapezoidal_step_pulse_generator_core
// Drives one stepper axis along a trapezoidal velocity profile. Commands are
// tick (one microsecond), start move, set position and load a step time table
// word; every command returns one result. Commands are handled one at a time.
// A tick that issues a step in the acceleration or deceleration phase picks
// the next interval through a bit-serial divider and a registered table
// read. A step in the coast phase, or with a zero acceleration count, skips
// the divider. The table reads as zero after reset until an entry is loaded.
// A new command is taken while the previous result still waits in the output
// register.
// ----------------------------------------------------------------------------
module trapezoidal_step_pulse_generator_core #(
    parameter int TABLE_ENTRIES = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_ready,
    input  tspg_pkg::cmd_t  cmd_data,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output tspg_pkg::rsp_t  rsp_data,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [23:0]     cfg_data
);

    import tspg_pkg::*;

    localparam int AW     = $clog2(TABLE_ENTRIES);
    localparam int QUOT_W = AW + 1;
    localparam int NUM_W  = 32 + AW;

    localparam logic [AW-1:0]     LAST      = AW'(TABLE_ENTRIES - 1);
    localparam logic [QUOT_W-1:0] LAST_Q    = {1'b0, LAST};
    localparam logic [AW+4:0]     ENTRIES_V = (AW+5)'(TABLE_ENTRIES);

    state_t              state_reg,    state_next;
    logic [31:0]         position_reg, position_next;
    logic                neg_reg,      neg_next;
    logic [31:0]         accel_reg,    accel_next;
    logic [31:0]         coast_reg,    coast_next;
    logic [31:0]         total_reg,    total_next;
    logic [31:0]         steps_reg,    steps_next;
    logic [12:0]         countdown_reg, countdown_next;
    logic [12:0]         interval_reg, interval_next;
    logic [23:0]         nominal_reg,  nominal_next;
    logic                pulse_reg,    pulse_next;
    logic                finish_reg,   finish_next;
    logic [31:0]         delta_reg,    delta_next;
    logic [31:0]         x_reg,        x_next;
    logic                decel_reg,    decel_next;
    logic [AW-1:0]       idx_reg,      idx_next;
    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;
    logic                rsp_valid_reg, rsp_valid_next;
    rsp_t                rsp_reg,      rsp_next;

    logic                accept;
    logic [AW+4:0]       tidx_ext;
    logic                ram_we;
    logic [15:0]         ram_rdata;
    logic                div_start;
    logic                div_done;
    logic [QUOT_W-1:0]   div_quot;
    logic [NUM_W-1:0]    div_numer;
    logic [33:0]         coast_s;
    logic [32:0]         ac_sum;
    logic [32:0]         s_ext;
    logic [32:0]         s_minus_ac;
    logic [31:0]         steps_inc;
    logic [15:0]         tbl_val;

    assign cmd_ready = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = cmd_valid && cmd_ready;
    assign tidx_ext  = {{AW{1'b0}}, cmd_data.table_index};

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    // product is registered inside the divider
    assign div_numer = {{AW{1'b0}}, x_reg} * {{32{1'b0}}, LAST};

    assign coast_s    = {2'b00, total_reg} - {9'd0, nominal_reg, 1'b0};
    assign ac_sum     = {1'b0, accel_reg} + {1'b0, coast_reg};
    assign s_ext      = {1'b0, steps_reg};
    assign s_minus_ac = s_ext - ac_sum;
    assign steps_inc  = steps_reg + 32'd1;
    assign tbl_val    = valid_reg[idx_reg] ? ram_rdata : 16'd0;

    tspg_ram #(
        .WIDTH (16),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tidx_ext[AW-1:0]),
        .wdata (cmd_data.table_value),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    tspg_div #(
        .QUOT_W (QUOT_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (div_numer),
        .denom (accel_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_comb
    begin
        state_next     = state_reg;
        position_next  = position_reg;
        neg_next       = neg_reg;
        accel_next     = accel_reg;
        coast_next     = coast_reg;
        total_next     = total_reg;
        steps_next     = steps_reg;
        countdown_next = countdown_reg;
        interval_next  = interval_reg;
        nominal_next   = nominal_reg;
        pulse_next     = pulse_reg;
        finish_next    = finish_reg;
        delta_next     = delta_reg;
        x_next         = x_reg;
        decel_next     = decel_reg;
        idx_next       = idx_reg;
        valid_next     = valid_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        ram_we         = 1'b0;
        div_start      = 1'b0;

        if (cfg_valid && cfg_ready)
        begin
            nominal_next = cfg_data;
        end
        if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    pulse_next  = 1'b0;
                    finish_next = 1'b0;
                    case (cmd_data.opcode)
                        OP_TICK:
                        begin
                            state_next = ST_TICK;
                        end
                        OP_START:
                        begin
                            delta_next = cmd_data.target_steps - position_reg;
                            state_next = ST_PLAN_ABS;
                        end
                        OP_SET:
                        begin
                            position_next = cmd_data.target_steps;
                            state_next    = ST_OUT;
                        end
                        OP_LOAD:
                        begin
                            if (tidx_ext < ENTRIES_V)
                            begin
                                ram_we                       = 1'b1;
                                valid_next[tidx_ext[AW-1:0]] = 1'b1;
                            end
                            state_next = ST_OUT;
                        end
                        default:
                        begin
                            state_next = ST_OUT;
                        end
                    endcase
                end
            end

            ST_PLAN_ABS:
            begin
                neg_next   = delta_reg[31];
                total_next = delta_reg[31] ? (32'd0 - delta_reg) : delta_reg;
                state_next = ST_PLAN_SPLIT;
            end

            ST_PLAN_SPLIT:
            begin
                // short move: halve it, the odd step goes to deceleration
                if (coast_s[33] || (coast_s == 34'd0))
                begin
                    accel_next = {1'b0, total_reg[31:1]};
                    coast_next = 32'd0;
                end
                else
                begin
                    accel_next = {8'd0, nominal_reg};
                    coast_next = coast_s[31:0];
                end
                steps_next     = 32'd0;
                interval_next  = START_INTERVAL;
                countdown_next = START_INTERVAL;
                state_next     = ST_OUT;
            end

            ST_TICK:
            begin
                if (total_reg == 32'd0)
                begin
                    state_next = ST_OUT;
                end
                else if (countdown_reg > 13'd1)
                begin
                    countdown_next = countdown_reg - 13'd1;
                    state_next     = ST_OUT;
                end
                else
                begin
                    pulse_next    = 1'b1;
                    position_next = neg_reg ? (position_reg - 32'd1)
                                            : (position_reg + 32'd1);
                    steps_next    = steps_inc;
                    if (steps_inc == total_reg)
                    begin
                        accel_next  = 32'd0;
                        coast_next  = 32'd0;
                        total_next  = 32'd0;
                        steps_next  = 32'd0;
                        finish_next = 1'b1;
                    end
                    state_next = ST_PHASE;
                end
            end

            ST_PHASE:
            begin
                if (steps_reg <= accel_reg)
                begin
                    if (accel_reg == 32'd0)
                    begin
                        idx_next   = '0;
                        state_next = ST_RDREQ;
                    end
                    else
                    begin
                        x_next     = steps_reg;
                        decel_next = 1'b0;
                        state_next = ST_MUL;
                    end
                end
                else if (s_ext <= ac_sum)
                begin
                    idx_next   = LAST;
                    state_next = ST_RDREQ;
                end
                else if (accel_reg == 32'd0)
                begin
                    idx_next   = '0;
                    state_next = ST_RDREQ;
                end
                else
                begin
                    // past the coast, at most accel+1 steps remain
                    x_next     = s_minus_ac[31:0];
                    decel_next = 1'b1;
                    state_next = ST_MUL;
                end
            end

            ST_MUL:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end

            ST_DIV:
            begin
                if (div_done)
                begin
                    if (decel_reg)
                    begin
                        idx_next = (div_quot > LAST_Q) ? '0 : (LAST - div_quot[AW-1:0]);
                    end
                    else
                    begin
                        idx_next = (div_quot > LAST_Q) ? LAST : div_quot[AW-1:0];
                    end
                    state_next = ST_RDREQ;
                end
            end

            ST_RDREQ:
            begin
                state_next = ST_RDDATA;
            end

            ST_RDDATA:
            begin
                if (tbl_val > {3'b000, INTERVAL_CAP})
                begin
                    interval_next = INTERVAL_CAP;
                end
                else
                begin
                    interval_next = tbl_val[12:0];
                end
                countdown_next = interval_next;
                state_next     = ST_OUT;
            end

            ST_OUT:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.step_pulse     = pulse_reg;
                    rsp_next.step_direction = neg_reg;
                    rsp_next.position_steps = position_reg;
                    rsp_next.moving         = (total_reg != 32'd0);
                    rsp_next.move_done      = finish_reg;
                    rsp_next.interval_us    = interval_reg;
                    rsp_valid_next          = 1'b1;
                    state_next              = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            position_reg  <= '0;
            neg_reg       <= 1'b0;
            accel_reg     <= '0;
            coast_reg     <= '0;
            total_reg     <= '0;
            steps_reg     <= '0;
            countdown_reg <= '0;
            interval_reg  <= '0;
            nominal_reg   <= '0;
            pulse_reg     <= 1'b0;
            finish_reg    <= 1'b0;
            valid_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            position_reg  <= position_next;
            neg_reg       <= neg_next;
            accel_reg     <= accel_next;
            coast_reg     <= coast_next;
            total_reg     <= total_next;
            steps_reg     <= steps_next;
            countdown_reg <= countdown_next;
            interval_reg  <= interval_next;
            nominal_reg   <= nominal_next;
            pulse_reg     <= pulse_next;
            finish_reg    <= finish_next;
            valid_reg     <= valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        delta_reg <= delta_next;
        x_reg     <= x_next;
        decel_reg <= decel_next;
        idx_reg   <= idx_next;
        rsp_reg   <= rsp_next;
    end

    // a finished move leaves no steps pending
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_data.move_done) |-> (rsp_data.step_pulse && !rsp_data.moving))
        else $error("move_done without final step");

    assert property (@(posedge clk) disable iff (!rst_n)
        interval_reg <= INTERVAL_CAP)
        else $error("interval above cap");

    // between commands a live move has steps left
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> ((total_reg == 32'd0) || (steps_reg < total_reg)))
        else $error("steps taken reached total without ending the move");

    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider result outside divide state");

endmodule
